// ===== hw/rtl/fcpa_pkg.sv =====
// Shared widths, status codes and register map of the cell pool allocator.
package fcpa_pkg;

	localparam int unsigned INDEX_W    = 10;
	localparam int unsigned COUNT_W    = 11;
	localparam int unsigned STATUS_W   = 2;
	localparam int unsigned INDEX_SPAN = 1024;
	localparam int unsigned APB_AW     = 3;
	localparam int unsigned APB_DW     = 32;

	localparam logic [COUNT_W-1:0] CELL_LIMIT_RESET = COUNT_W'(1024);

	localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL         = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_INVALID_FREE = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_UNUSED       = 2'd3;

	localparam logic ACTION_ALLOC = 1'b0;
	localparam logic ACTION_FREE  = 1'b1;

	localparam logic REG_CELL_LIMIT = 1'b0;

endpackage

// ===== hw/rtl/fcpa_link_mem.sv =====
// Link memory of the free list: one write port, one registered read port.
module fcpa_link_mem #(
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [AW-1:0]                wr_addr,
	input  logic [fcpa_pkg::INDEX_W-1:0] wr_data,
	input  logic                         rd_en,
	input  logic [AW-1:0]                rd_addr,
	output logic [fcpa_pkg::INDEX_W-1:0] rd_data
);

	logic [fcpa_pkg::INDEX_W-1:0] mem [DEPTH];
	logic [fcpa_pkg::INDEX_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hw/rtl/fixed_cell_pool_allocator.sv =====
// Fixed-size cell pool allocator: LIFO free list in a link memory plus bump pointer.
// Each result is registered and shows on the outputs in the cycle after its request transfer.
// Throughput: one request per cycle while in_stall is low; after an allocate served from the
// free list, in_stall holds off the next request until the next list head comes back from the link memory.
// Reset: counters, bump mark, list head and handshake state clear, cell_limit is 1024;
// the link memory is not cleared and needs no clearing pass.
module fixed_cell_pool_allocator #(
	parameter int unsigned NUM_CELLS = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              action,
	input  logic [fcpa_pkg::INDEX_W-1:0]      cell_index,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [fcpa_pkg::INDEX_W-1:0]      granted_index,
	output logic [fcpa_pkg::STATUS_W-1:0]     status,
	output logic [fcpa_pkg::COUNT_W-1:0]      cells_in_use,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [fcpa_pkg::APB_AW-1:0]       paddr,
	input  logic [fcpa_pkg::APB_DW-1:0]       pwdata,
	output logic [fcpa_pkg::APB_DW-1:0]       prdata,
	output logic                              pready
);

	localparam int unsigned MEM_DEPTH = (NUM_CELLS < fcpa_pkg::INDEX_SPAN) ?
		NUM_CELLS : fcpa_pkg::INDEX_SPAN;
	localparam int unsigned AW = $clog2(MEM_DEPTH);
	localparam logic [fcpa_pkg::COUNT_W-1:0] LIMIT_CAP = fcpa_pkg::COUNT_W'(MEM_DEPTH);

	logic [fcpa_pkg::COUNT_W-1:0]  cell_limit_q;
	logic [fcpa_pkg::INDEX_W-1:0]  free_head_q;
	logic                          nonempty_q;
	logic [fcpa_pkg::COUNT_W-1:0]  bump_q;
	logic [fcpa_pkg::COUNT_W-1:0]  count_q;
	logic                          busy_q;
	logic                          out_valid_q;
	logic [fcpa_pkg::INDEX_W-1:0]  granted_q;
	logic [fcpa_pkg::STATUS_W-1:0] status_q;
	logic [fcpa_pkg::COUNT_W-1:0]  in_use_q;

	logic                          accept;
	logic                          cfg_wr;
	logic [fcpa_pkg::COUNT_W-1:0]  eff_limit;
	logic [fcpa_pkg::COUNT_W-1:0]  idx_ext;
	logic [fcpa_pkg::COUNT_W-1:0]  count_inc;
	logic [fcpa_pkg::COUNT_W-1:0]  count_dec;
	logic                          is_full;
	logic                          free_bad;
	logic                          do_pop;
	logic                          do_bump;
	logic                          do_push;
	logic [fcpa_pkg::INDEX_W-1:0]  link_rd;
	logic [fcpa_pkg::INDEX_W-1:0]  res_granted;
	logic [fcpa_pkg::STATUS_W-1:0] res_status;
	logic [fcpa_pkg::COUNT_W-1:0]  res_count;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == fcpa_pkg::REG_CELL_LIMIT) ?
		fcpa_pkg::APB_DW'(cell_limit_q) : '0;

	assign in_stall = busy_q || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;

	assign eff_limit = (cell_limit_q > LIMIT_CAP) ? LIMIT_CAP : cell_limit_q;
	assign idx_ext   = {1'b0, cell_index};
	assign count_inc = count_q + 1'b1;
	assign count_dec = count_q - 1'b1;
	assign is_full   = count_q >= eff_limit;
	assign free_bad  = (count_q == '0) || (idx_ext >= bump_q) || (idx_ext >= LIMIT_CAP);

	assign do_pop  = accept && (action == fcpa_pkg::ACTION_ALLOC) && !is_full && nonempty_q;
	assign do_bump = accept && (action == fcpa_pkg::ACTION_ALLOC) && !is_full && !nonempty_q;
	assign do_push = accept && (action == fcpa_pkg::ACTION_FREE) && !free_bad;

	always_comb begin
		res_granted = '0;
		res_status  = fcpa_pkg::STATUS_OK;
		res_count   = count_q;
		if (action == fcpa_pkg::ACTION_ALLOC) begin
			if (is_full) begin
				res_status = fcpa_pkg::STATUS_FULL;
			end else if (nonempty_q) begin
				res_granted = free_head_q;
				res_count   = count_inc;
			end else begin
				res_granted = bump_q[fcpa_pkg::INDEX_W-1:0];
				res_count   = count_inc;
			end
		end else begin
			if (free_bad) begin
				res_status = fcpa_pkg::STATUS_INVALID_FREE;
			end else begin
				res_count = count_dec;
			end
		end
	end

	fcpa_link_mem #(
		.DEPTH(MEM_DEPTH)
	) u_link_mem (
		.clk     (clk),
		.wr_en   (do_push),
		.wr_addr (cell_index[AW-1:0]),
		.wr_data (free_head_q),
		.rd_en   (do_pop),
		.rd_addr (free_head_q[AW-1:0]),
		.rd_data (link_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_limit_q <= fcpa_pkg::CELL_LIMIT_RESET;
			free_head_q  <= '0;
			nonempty_q   <= 1'b0;
			bump_q       <= '0;
			count_q      <= '0;
			busy_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr && (paddr[2] == fcpa_pkg::REG_CELL_LIMIT)) begin
				cell_limit_q <= pwdata[fcpa_pkg::COUNT_W-1:0];
			end
			// take the new list head once the link read returns
			if (busy_q) begin
				free_head_q <= link_rd;
				busy_q      <= 1'b0;
			end
			if (do_pop) begin
				busy_q     <= 1'b1;
				count_q    <= count_inc;
				nonempty_q <= count_inc < bump_q;
			end
			if (do_bump) begin
				bump_q  <= bump_q + 1'b1;
				count_q <= count_inc;
			end
			if (do_push) begin
				free_head_q <= cell_index;
				nonempty_q  <= 1'b1;
				count_q     <= count_dec;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			granted_q <= res_granted;
			status_q  <= res_status;
			in_use_q  <= res_count;
		end
	end

	assign out_valid     = out_valid_q;
	assign granted_index = granted_q;
	assign status        = status_q;
	assign cells_in_use  = in_use_q;

endmodule

// ===== hw/rtl/fcpa_checker.sv =====
// Port-level checks of the cell pool allocator and their binding to the top level.
module fcpa_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [fcpa_pkg::INDEX_W-1:0]  granted_index,
	input logic [fcpa_pkg::STATUS_W-1:0] status,
	input logic [fcpa_pkg::COUNT_W-1:0]  cells_in_use
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(granted_index) &&
		$stable(status) && $stable(cells_in_use))
		else $error("stalled result changed");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != fcpa_pkg::STATUS_UNUSED)
		else $error("undefined status code");

	a_no_grant_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != fcpa_pkg::STATUS_OK |-> granted_index == '0)
		else $error("index granted on a failed request");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cells_in_use <= fcpa_pkg::COUNT_W'(fcpa_pkg::INDEX_SPAN))
		else $error("cells in use beyond index span");

endmodule

bind fixed_cell_pool_allocator fcpa_checker u_fcpa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.granted_index (granted_index),
	.status        (status),
	.cells_in_use  (cells_in_use)
);

// ===== bench/fixed_cell_pool_allocator_test.sv =====
// Self-checking bench for the cell pool allocator: predicts each reply and scores it.
typedef struct packed {
	logic [fcpa_pkg::INDEX_W-1:0]  granted;
	logic [fcpa_pkg::STATUS_W-1:0] status;
	logic [fcpa_pkg::COUNT_W-1:0]  in_use;
} pool_reply_t;

class pool_ledger;
	logic [fcpa_pkg::INDEX_W-1:0] link_mem [fcpa_pkg::INDEX_SPAN];
	logic [fcpa_pkg::INDEX_W-1:0] head;
	bit                           list_nonempty;
	int unsigned                  bump;
	int unsigned                  in_use;
	int unsigned                  limit;
	int unsigned                  mismatches;
	pool_reply_t                  pending_replies [$];

	function new();
		head = '0;
		list_nonempty = 0;
		bump = 0;
		in_use = 0;
		limit = fcpa_pkg::CELL_LIMIT_RESET;
		mismatches = 0;
	endfunction

	function void set_limit(logic [fcpa_pkg::COUNT_W-1:0] value);
		limit = value;
	endfunction

	function int unsigned outstanding();
		return pending_replies.size();
	endfunction

	function pool_reply_t note_request(logic act, logic [fcpa_pkg::INDEX_W-1:0] idx);
		pool_reply_t reply;
		int unsigned eff;
		reply = '0;
		reply.status = fcpa_pkg::STATUS_OK;
		eff = (limit > fcpa_pkg::INDEX_SPAN) ? fcpa_pkg::INDEX_SPAN : limit;
		if (act == fcpa_pkg::ACTION_ALLOC) begin
			if (in_use >= eff) begin
				reply.status = fcpa_pkg::STATUS_FULL;
			end else if (list_nonempty) begin
				reply.granted = head;
				head = link_mem[head];
				in_use++;
				list_nonempty = (in_use < bump);
			end else begin
				reply.granted = fcpa_pkg::INDEX_W'(bump);
				bump++;
				in_use++;
			end
		end else if (in_use == 0 || idx >= bump) begin
			reply.status = fcpa_pkg::STATUS_INVALID_FREE;
		end else begin
			link_mem[idx] = head;
			head = idx;
			list_nonempty = 1;
			in_use--;
		end
		reply.in_use = fcpa_pkg::COUNT_W'(in_use);
		pending_replies.push_back(reply);
		return reply;
	endfunction

	function void check_reply(logic [fcpa_pkg::INDEX_W-1:0] granted,
			logic [fcpa_pkg::STATUS_W-1:0] status, logic [fcpa_pkg::COUNT_W-1:0] in_use_now);
		pool_reply_t want;
		if (pending_replies.size() == 0) begin
			$error("unexpected transfer: granted_index %0d status %0d cells_in_use %0d",
				granted, status, in_use_now);
			mismatches++;
			return;
		end
		want = pending_replies.pop_front();
		if (granted !== want.granted) begin
			$error("granted_index expected %0d actual %0d", want.granted, granted);
			mismatches++;
		end
		if (status !== want.status) begin
			$error("status expected %0d actual %0d", want.status, status);
			mismatches++;
		end
		if (in_use_now !== want.in_use) begin
			$error("cells_in_use expected %0d actual %0d", want.in_use, in_use_now);
			mismatches++;
		end
	endfunction
endclass

module fixed_cell_pool_allocator_test;

	localparam int unsigned CYCLE_LIMIT = 400000;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic                          action = fcpa_pkg::ACTION_ALLOC;
	logic [fcpa_pkg::INDEX_W-1:0]  cell_index = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [fcpa_pkg::INDEX_W-1:0]  granted_index;
	logic [fcpa_pkg::STATUS_W-1:0] status;
	logic [fcpa_pkg::COUNT_W-1:0]  cells_in_use;
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [fcpa_pkg::APB_AW-1:0]   paddr = '0;
	logic [fcpa_pkg::APB_DW-1:0]   pwdata = '0;
	logic [fcpa_pkg::APB_DW-1:0]   prdata;
	logic                          pready;

	pool_ledger                    ledger = new();
	logic [fcpa_pkg::INDEX_W-1:0]  held_cells [$];
	bit                            calm = 0;
	int unsigned                   cycle_count = 0;

	fixed_cell_pool_allocator #(.NUM_CELLS(fcpa_pkg::INDEX_SPAN)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .cell_index(cell_index),
		.out_valid(out_valid), .out_stall(out_stall),
		.granted_index(granted_index), .status(status), .cells_in_use(cells_in_use),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			ledger.check_reply(granted_index, status, cells_in_use);
	end

	initial begin
		@(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("fixed_cell_pool_allocator_test NOT OK");
		$finish;
	end

	task automatic send_request(input logic act, input logic [fcpa_pkg::INDEX_W-1:0] idx);
		pool_reply_t reply;
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		cell_index <= idx;
		do @(posedge clk); while (in_stall);
		reply = ledger.note_request(act, idx);
		if (reply.status == fcpa_pkg::STATUS_OK) begin
			if (act == fcpa_pkg::ACTION_ALLOC) begin
				held_cells.push_back(reply.granted);
			end else begin
				for (int i = 0; i < held_cells.size(); i++) begin
					if (held_cells[i] == idx) begin
						held_cells.delete(i);
						break;
					end
				end
			end
		end
	endtask

	task automatic wait_until_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (ledger.outstanding() != 0);
	endtask

	task automatic set_cell_limit(input logic [fcpa_pkg::COUNT_W-1:0] value);
		wait_until_drained();
		repeat (4) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= fcpa_pkg::APB_AW'(4 * fcpa_pkg::REG_CELL_LIMIT);
		pwdata <= fcpa_pkg::APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		ledger.set_limit(value);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== fcpa_pkg::APB_DW'(value)) begin
			$error("cell_limit expected %0d actual %0d", value, prdata);
			ledger.mismatches++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic run_phase(input int unsigned limit, input int unsigned items,
			input int unsigned alloc_pct, input bit pause_mid);
		logic                          act;
		logic [fcpa_pkg::INDEX_W-1:0]  idx;
		int unsigned                   pick;
		set_cell_limit(fcpa_pkg::COUNT_W'(limit));
		for (int n = 0; n < items; n++) begin
			if (pause_mid && n == items / 2)
				wait_until_drained();
			idx = fcpa_pkg::INDEX_W'($urandom_range(0, fcpa_pkg::INDEX_SPAN - 1));
			if ($urandom_range(0, 99) < alloc_pct) begin
				act = fcpa_pkg::ACTION_ALLOC;
			end else begin
				act = fcpa_pkg::ACTION_FREE;
				pick = $urandom_range(0, 99);
				if (pick >= 6 && pick < 9 && ledger.bump > 0)
					idx = fcpa_pkg::INDEX_W'($urandom_range(0, ledger.bump - 1));
				else if (pick >= 9 && held_cells.size() > 0)
					idx = held_cells[$urandom_range(0, held_cells.size() - 1)];
			end
			send_request(act, idx);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(fcpa_pkg::ACTION_FREE, 10'd0);
		send_request(fcpa_pkg::ACTION_FREE, 10'd1023);
		send_request(fcpa_pkg::ACTION_ALLOC, 10'd1023);
		send_request(fcpa_pkg::ACTION_ALLOC, 10'd0);
		send_request(fcpa_pkg::ACTION_ALLOC, 10'd512);
		send_request(fcpa_pkg::ACTION_FREE, 10'd3);
		send_request(fcpa_pkg::ACTION_FREE, 10'd1023);
		send_request(fcpa_pkg::ACTION_FREE, 10'd1);
		send_request(fcpa_pkg::ACTION_FREE, 10'd0);
		send_request(fcpa_pkg::ACTION_ALLOC, 10'd0);
		send_request(fcpa_pkg::ACTION_ALLOC, 10'd0);
		send_request(fcpa_pkg::ACTION_ALLOC, 10'd0);
		send_request(fcpa_pkg::ACTION_FREE, 10'd2);
		send_request(fcpa_pkg::ACTION_FREE, 10'd3);
		send_request(fcpa_pkg::ACTION_FREE, 10'd0);
		send_request(fcpa_pkg::ACTION_ALLOC, 10'd341);
		send_request(fcpa_pkg::ACTION_ALLOC, 10'd682);
		set_cell_limit(fcpa_pkg::COUNT_W'(1));
		send_request(fcpa_pkg::ACTION_ALLOC, 10'd0);
		send_request(fcpa_pkg::ACTION_FREE, 10'd0);
		send_request(fcpa_pkg::ACTION_FREE, 10'd3);
		send_request(fcpa_pkg::ACTION_FREE, 10'd1);
		send_request(fcpa_pkg::ACTION_ALLOC, 10'd0);
		send_request(fcpa_pkg::ACTION_ALLOC, 10'd0);
		send_request(fcpa_pkg::ACTION_FREE, 10'd1);

		run_phase(1, 150, 50, 0);
		run_phase(2, 150, 55, 0);
		run_phase($urandom_range(3, 40), 200, 60, 0);
		run_phase(fcpa_pkg::INDEX_SPAN, 1060, 99, 0);
		run_phase($urandom_range(512, 1000), 200, 25, 1);
		calm = 1;
		run_phase($urandom_range(1, fcpa_pkg::INDEX_SPAN), 200, 50, 0);

		wait_until_drained();
		repeat (8) @(posedge clk);
		if (ledger.mismatches == 0 && ledger.outstanding() == 0)
			$display("fixed_cell_pool_allocator_test OK");
		else
			$display("fixed_cell_pool_allocator_test NOT OK");
		$finish;
	end

endmodule
